[hdl/kwos_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kwos_pkg: shared types and constants
// Field widths, command codes and controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package kwos_pkg;

  localparam int MAX_SITES_DEF = 1024;
  localparam int CMD_W         = 2;
  localparam int SEQ_W         = 16;
  localparam int POS_W         = 32;
  localparam int LEN_W         = 8;
  localparam logic [LEN_W-1:0] LEN_RST = 8'd30;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } kwos_op_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic rd_issue;  // read next table entry
    logic res_set;   // move pending result into output register
  } kwos_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;  // table empty
    logic issue_last;  // current read is the last valid entry
  } kwos_sts_t;

endpackage
`default_nettype wire

[hdl/kwos_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kwos_if: channel interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
interface kwos_in_if import kwos_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SEQ_W-1:0] sequence_id;
  logic [POS_W-1:0] position;
  modport source (output valid, cmd, sequence_id, position, input ready);
  modport sink   (input valid, cmd, sequence_id, position, output ready);
endinterface

interface kwos_out_if ();
  logic valid;
  logic ready;
  logic is_hit;
  logic table_full;
  modport source (output valid, is_hit, table_full, input ready);
  modport sink   (input valid, is_hit, table_full, output ready);
endinterface

interface kwos_cfg_if import kwos_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] kmer_length;
  modport source (output valid, kmer_length, input ready);
  modport sink   (input valid, kmer_length, output ready);
endinterface
`default_nettype wire

[hdl/kmer_window_overlap_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmer_window_overlap_search: site table with k-mer window lookup
// Holds up to MAX_SITES (sequence id, position) sites and answers whether a
// k-mer window covers any of them.
// ---------------------------------------------------------------------------
// Every input item gives exactly one result item. Clear, load and the unused
// command occupy the block for the accepting cycle, in which the command
// acts, and a hand-off step that waits for the output register to be free
// and then moves the result into it. A query reads the site memory one
// entry per cycle over the filled part of the table, waits for the last
// compare and then hands the result to the output register; on an empty
// table it goes straight to the hand-off. The single read port of the site
// memory sets the pace of the scan. The scan always runs to the fill count.
// Sites are appended in order; a load into a full table is dropped and
// flagged with table_full. A site matches when its id equals the query id
// and start <= site <= start + kmer_length - 1, computed without wrap; a
// kmer_length of zero never matches. The output register lets a new item be
// accepted while the previous result still waits. kmer_length resets to 30
// and may be written at any time the block is idle; the write port is
// always ready. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module kmer_window_overlap_search import kwos_pkg::*; #(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kwos_in_if.sink    in_if,
  kwos_out_if.source out_if,
  kwos_cfg_if.sink   cfg_if
);

  kwos_ctl_t ctl;
  kwos_sts_t sts;
  kwos_op_t  in_op;
  logic      cfg_we;

  assign in_op        = kwos_op_t'(in_if.cmd);
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;

  // sequencing: accept, scan stepping, result hand-off
  kwos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // site memory, fill count, window compare and result registers
  kwos_datapath #(
    .MAX_SITES (MAX_SITES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (in_op),
    .in_seq     (in_if.sequence_id),
    .in_pos     (in_if.position),
    .cfg_we     (cfg_we),
    .cfg_len    (cfg_if.kmer_length),
    .is_hit     (out_if.is_hit),
    .table_full (out_if.table_full)
  );

endmodule
`default_nettype wire

[hdl/kwos_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kwos_datapath: site table and window compare
// Site memory, fill count, scan index, query latch, result registers.
// ---------------------------------------------------------------------------
module kwos_datapath import kwos_pkg::*; #(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kwos_ctl_t        ctl,
  output      kwos_sts_t        sts,
  input  wire kwos_op_t         in_cmd,
  input  wire logic [SEQ_W-1:0] in_seq,
  input  wire logic [POS_W-1:0] in_pos,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_len,
  output      logic             is_hit,
  output      logic             table_full
);

  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SITES);

  logic [SEQ_W-1:0] seq_mem [MAX_SITES];
  logic [POS_W-1:0] pos_mem [MAX_SITES];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_vld_r;
  logic [LEN_W-1:0] len_r;
  logic [SEQ_W-1:0] q_seq_r;
  logic [POS_W-1:0] q_pos_r;
  logic [SEQ_W-1:0] rd_seq_r;
  logic [POS_W-1:0] rd_pos_r;
  logic             pend_hit_r, pend_hit_nxt;
  logic             pend_full_r, pend_full_nxt;
  logic             hit_r;
  logic             full_r;

  logic             is_full;
  logic             do_write;
  logic [POS_W:0]   diff;
  logic             match;

  assign is_full  = (count_r == CNT_MAX);
  assign do_write = ctl.accept && (in_cmd == CMD_LOAD) && !is_full;

  // site - start in widened arithmetic; inside when no borrow and below len
  assign diff  = {1'b0, rd_pos_r} - {1'b0, q_pos_r};
  assign match = (rd_seq_r == q_seq_r) && (diff[POS_W:LEN_W] == '0) &&
                 (diff[LEN_W-1:0] < len_r);

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_hit_nxt  = pend_hit_r;
    pend_full_nxt = pend_full_r;
    if (ctl.accept) begin
      pend_hit_nxt  = 1'b0;
      pend_full_nxt = 1'b0;
      idx_nxt       = '0;
      case (in_cmd)
        CMD_CLEAR: count_nxt = '0;
        CMD_LOAD: begin
          if (is_full) begin
            pend_full_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ctl.rd_issue) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmp_vld_r && match) begin
      pend_hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      len_r     <= LEN_RST;
    end else begin
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= ctl.rd_issue;
      if (cfg_we) begin
        len_r <= cfg_len;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_hit_r  <= pend_hit_nxt;
    pend_full_r <= pend_full_nxt;
    if (ctl.accept) begin
      q_seq_r <= in_seq;
      q_pos_r <= in_pos;
    end
    if (ctl.res_set) begin
      hit_r  <= pend_hit_r;
      full_r <= pend_full_r;
    end
  end

  // site memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      seq_mem[count_r[IDX_W-1:0]] <= in_seq;
      pos_mem[count_r[IDX_W-1:0]] <= in_pos;
    end
    if (ctl.rd_issue) begin
      rd_seq_r <= seq_mem[idx_r[IDX_W-1:0]];
      rd_pos_r <= pos_mem[idx_r[IDX_W-1:0]];
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.issue_last = ((idx_r + 1'b1) == count_r);

  assign is_hit     = hit_r;
  assign table_full = full_r;

endmodule
`default_nettype wire

[hdl/kwos_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kwos_ctrl: sequencing controller
// Takes one item, steps the table scan for queries, hands off the result.
// ---------------------------------------------------------------------------
module kwos_ctrl import kwos_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire kwos_op_t  in_cmd,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      kwos_ctl_t ctl,
  input  wire kwos_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (in_cmd == CMD_QUERY && !sts.count_zero) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        ctl.rd_issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;  // last compare lands this cycle
      ST_DONE: begin
        if (slot_free) begin
          ctl.res_set   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[tb/kmer_window_overlap_search_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmer_window_overlap_search_tb: self-checking bench for the site table
// Drives clear, load, query and unused commands through the input channel,
// mirrors the site table and window match in a local predictor, and checks
// every result item in order. Idling on both sides, a long receiver
// hold-off, a filled table and several k-mer lengths are exercised.
// ---------------------------------------------------------------------------
module kmer_window_overlap_search_tb;
  import kwos_pkg::*;

  localparam int TABLE_DEPTH = MAX_SITES_DEF;
  localparam int WIN_W       = POS_W + 1;    // window end needs one spare bit
  localparam int STUCK_LIMIT = 10000;        // must outlast a full-table scan
  localparam int SETTLE_CYC  = 40;           // tail wait after the last result
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    kwos_op_t         op;
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } table_cmd_t;

  typedef struct packed {
    logic is_hit;
    logic table_full;
  } table_answer_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } site_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  kwos_in_if  in_ch ();
  kwos_out_if out_ch ();
  kwos_cfg_if cfg_ch ();

  kmer_window_overlap_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Mirror of the block: site table, fill count and current k-mer length.
  // Updated at the edge where an item or a length write is accepted.
  // -------------------------------------------------------------------------
  logic [SEQ_W-1:0] mirror_seq [TABLE_DEPTH];
  logic [POS_W-1:0] mirror_pos [TABLE_DEPTH];
  int               mirror_count = 0;
  logic [LEN_W-1:0] mirror_klen  = LEN_RST;

  // Stimulus side: items waiting for the driver, and the answers owed by
  // the block in acceptance order.
  table_cmd_t    queued_cmds[$];
  table_answer_t owed_answers[$];

  // Generator's own view of the table, so queries can be aimed at sites.
  site_t            gen_sites[$];
  logic [LEN_W-1:0] gen_klen = LEN_RST;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req     = 0;   // bumped by the sequencer to ask for a hold-off
  int stall_len     = 0;

  int n_sent       = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_queries    = 0;
  int n_hits       = 0;
  int n_refused    = 0;
  int n_len_writes = 0;
  int err_count    = 0;
  int stuck_cycles = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Applies one command to the mirror and returns the answer it owes.
  // Window is start .. start+len-1 worked out one bit wider, so a window
  // running past the top of the position range never wraps to low sites.
  function automatic table_answer_t apply_table_cmd(input table_cmd_t c);
    table_answer_t    ans;
    logic [WIN_W-1:0] win_last;
    ans      = '0;
    win_last = WIN_W'(c.pos) + WIN_W'(mirror_klen) - WIN_W'(1);
    case (c.op)
      CMD_CLEAR: mirror_count = 0;   // entries stay but are no longer valid
      CMD_LOAD: begin
        if (mirror_count >= TABLE_DEPTH) begin
          ans.table_full = 1'b1;      // dropped, table unchanged
        end else begin
          mirror_seq[mirror_count] = c.seq;
          mirror_pos[mirror_count] = c.pos;
          mirror_count++;
        end
      end
      CMD_QUERY: begin
        // zero length: empty window, never a hit
        if (mirror_klen != '0) begin
          for (int i = 0; i < mirror_count; i++) begin
            if (mirror_seq[i] == c.seq && mirror_pos[i] >= c.pos &&
                WIN_W'(mirror_pos[i]) <= win_last) ans.is_hit = 1'b1;
          end
        end
      end
      default: ;                       // unused command: no effect
    endcase
    return ans;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // Small id pool so loads and queries collide, plus the extremes.
  function automatic logic [SEQ_W-1:0] rand_seq_id();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return SEQ_W'($urandom_range(3));
      6:                return '1;
      7:                return '0;
      default:          return SEQ_W'($urandom);
    endcase
  endfunction

  // Mostly anywhere; sometimes near zero or near the top of the range.
  function automatic logic [POS_W-1:0] rand_position();
    case ($urandom_range(9))
      0:       return POS_W'($urandom_range(40));
      1:       return '1 - POS_W'($urandom_range(300));
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic push_cmd(input kwos_op_t op, input logic [SEQ_W-1:0] seq,
                          input logic [POS_W-1:0] pos);
    table_cmd_t c;
    c.op  = op;
    c.seq = seq;
    c.pos = pos;
    queued_cmds.push_back(c);
    if (op == CMD_CLEAR) gen_sites.delete();
    else if (op == CMD_LOAD && gen_sites.size() < TABLE_DEPTH)
      gen_sites.push_back({seq, pos});
  endtask

  // Random mix: loads and queries dominate, queries mostly aimed at a stored
  // site with a start offset around the window edges. Table kept small so
  // scans stay short; a clear is forced once it reaches 48 sites.
  task automatic queue_random_cmds(input int count);
    int               pick;
    site_t            s;
    logic [POS_W-1:0] start;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_cmd(CMD_CLEAR, rand_seq_id(), rand_position());
      end else if (pick < 6) begin
        push_cmd(CMD_NOP, SEQ_W'($urandom), POS_W'($urandom));
      end else if (pick < 48) begin
        if (gen_sites.size() >= 48) push_cmd(CMD_CLEAR, rand_seq_id(), rand_position());
        else push_cmd(CMD_LOAD, rand_seq_id(), rand_position());
      end else if (pick < 82 && gen_sites.size() != 0) begin
        s = gen_sites[$urandom_range(gen_sites.size() - 1)];
        if ($urandom_range(9) == 0) s.seq = s.seq ^ (SEQ_W'(1) << $urandom_range(SEQ_W - 1));
        if ($urandom_range(9) == 0) start = s.pos + POS_W'($urandom_range(3, 1));
        else start = s.pos - POS_W'($urandom_range(int'(gen_klen) + 1));
        push_cmd(CMD_QUERY, s.seq, start);
      end else begin
        push_cmd(CMD_QUERY, rand_seq_id(), rand_position());
      end
    end
  endtask

  // Fill to the brim, provoke refused loads, scan a full table (marker site
  // sits in the last slot so only a complete scan finds it), then clear.
  task automatic queue_full_table();
    push_cmd(CMD_CLEAR, '0, '0);
    for (int i = 0; i < TABLE_DEPTH - 1; i++) push_cmd(CMD_LOAD, rand_seq_id(), rand_position());
    push_cmd(CMD_LOAD, 16'hA5C3, 32'h8000_0000);
    push_cmd(CMD_LOAD, '1, '1);
    push_cmd(CMD_LOAD, '0, '0);
    push_cmd(CMD_LOAD, 16'hA5C3, 32'h8000_0001);
    push_cmd(CMD_QUERY, 16'hA5C3, 32'h8000_0000 - POS_W'(gen_klen) + POS_W'(1));
    push_cmd(CMD_QUERY, 16'hA5C3, 32'h8000_0001);
    push_cmd(CMD_QUERY, gen_sites[0].seq, gen_sites[0].pos);
    push_cmd(CMD_CLEAR, '1, '1);
    push_cmd(CMD_QUERY, 16'hA5C3, 32'h8000_0000);
    push_cmd(CMD_LOAD, 16'hA5C3, 32'h8000_0000);
    push_cmd(CMD_QUERY, 16'hA5C3, 32'h8000_0000);
  endtask

  // Waits until every queued item is taken and every answer has come back.
  // Each item yields exactly one result, so the block is idle afterwards.
  task automatic drain_results();
    while (queued_cmds.size() != 0 || n_sent != n_accepted || owed_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_kmer_length(input logic [LEN_W-1:0] len);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.kmer_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    gen_klen = len;
    n_len_writes++;
  endtask

  task automatic request_hold_off(input int cycles);
    stall_len = cycles;
    stall_req++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: offers the next queued item at the falling edge, holds it until
  // taken, and idles at random by send_idle_pct.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    table_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || n_accepted == n_sent) begin
      if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_cmds.pop_front();
        in_ch.cmd         <= nxt.op;
        in_ch.sequence_id <= nxt.seq;
        in_ch.position    <= nxt.pos;
        in_ch.valid       <= 1'b1;
        n_sent++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // output register and the input side both fill up.
  int hold_left  = 0;
  int stall_seen = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen   <= stall_req;
      hold_left    <= stall_len;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: at the rising edge, mirror accepted items and length writes,
  // and check each result item against the oldest owed answer.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    table_cmd_t    seen;
    table_answer_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) mirror_klen = cfg_ch.kmer_length;
      if (in_ch.valid && in_ch.ready) begin
        seen.op  = kwos_op_t'(in_ch.cmd);
        seen.seq = in_ch.sequence_id;
        seen.pos = in_ch.position;
        if (seen.op == CMD_QUERY) n_queries++;
        owed_answers.push_back(apply_table_cmd(seen));
        n_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_answers.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed (is_hit %b table_full %b)",
                                    out_ch.is_hit, out_ch.table_full));
        end else begin
          want = owed_answers.pop_front();
          if (out_ch.is_hit !== want.is_hit)
            report_mismatch($sformatf("result %0d is_hit %b, expected %b",
                                      n_checked, out_ch.is_hit, want.is_hit));
          if (out_ch.table_full !== want.table_full)
            report_mismatch($sformatf("result %0d table_full %b, expected %b",
                                      n_checked, out_ch.table_full, want.table_full));
          if (want.is_hit) n_hits++;
          if (want.table_full) n_refused++;
          n_checked++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d answers still owed",
               stuck_cycles, owed_answers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: reset, directed items at the reset length, then random
  // phases over several lengths and the three idling modes.
  // -------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_NOP;
    in_ch.sequence_id  = '0;
    in_ch.position     = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.kmer_length = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Mode A: sender rarely idles, receiver mostly stalls.
    send_idle_pct = 6;
    recv_idle_pct = 83;

    // Directed, length 30 from reset.
    push_cmd(CMD_QUERY, 16'h1234, 32'd1000);          // empty table
    push_cmd(CMD_NOP, '1, '1);                        // unused command
    push_cmd(CMD_LOAD, '1, '1);
    push_cmd(CMD_LOAD, '0, '0);
    push_cmd(CMD_LOAD, 16'h1234, 32'd1000);
    push_cmd(CMD_QUERY, '1, '1);                      // start on the site
    push_cmd(CMD_QUERY, '1, 32'hFFFF_FFE2);           // last base on top site
    push_cmd(CMD_QUERY, '1, 32'hFFFF_FFE1);           // one short
    push_cmd(CMD_QUERY, '0, '0);
    push_cmd(CMD_QUERY, '0, 32'hFFFF_FFF0);           // would hit site 0 if it wrapped
    push_cmd(CMD_QUERY, 16'h1234, 32'd971);           // site is last base
    push_cmd(CMD_QUERY, 16'h1234, 32'd970);           // just outside
    push_cmd(CMD_QUERY, 16'h1235, 32'd1000);          // id differs
    push_cmd(CMD_QUERY, 16'h1234, 32'd1001);          // start past site
    push_cmd(CMD_CLEAR, '0, '0);
    push_cmd(CMD_QUERY, 16'h1234, 32'd1000);          // cleared entries invisible
    push_cmd(CMD_LOAD, 16'h1234, 32'd1000);
    push_cmd(CMD_QUERY, 16'h1234, 32'd1000);
    drain_results();

    write_kmer_length(8'd1);
    queue_random_cmds(90);
    drain_results();

    // Long receiver hold-off while items keep coming.
    write_kmer_length(8'd200);
    queue_random_cmds(90);
    request_hold_off(300);
    drain_results();

    // Mode B: sender mostly idles, receiver rarely stalls.
    send_idle_pct = 83;
    recv_idle_pct = 6;
    write_kmer_length(8'd0);                          // every query misses
    queue_random_cmds(80);
    drain_results();

    write_kmer_length(8'd255);                        // beyond the nominal range
    queue_random_cmds(100);
    drain_results();

    // Mode C: no idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_kmer_length(8'd17);
    queue_full_table();
    drain_results();

    write_kmer_length(LEN_W'($urandom_range(199, 2)));
    queue_random_cmds(110);
    drain_results();

    write_kmer_length(8'd30);
    queue_random_cmds(110);
    request_hold_off(300);
    drain_results();

    repeat (SETTLE_CYC) @(posedge clk);
    if (owed_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", owed_answers.size()));

    $display("Run: %0d items checked, %0d queries with %0d hits, %0d refused loads",
             n_checked, n_queries, n_hits, n_refused);
    $display("     over %0d k-mer lengths (0, 1, 200, 255 among them), %0d mismatches",
             n_len_writes, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/kwos_pkg.sv
hdl/kwos_if.sv
hdl/kwos_datapath.sv
hdl/kwos_ctrl.sv
hdl/kmer_window_overlap_search.sv
tb/kmer_window_overlap_search_tb.sv
